// ----- src/trihex_chunk_neighbour_addresses_top_defines.svh -----
// assertion macros used by the checker file
`ifndef TRIHEX_CHUNK_NEIGHBOUR_ADDRESSES_TOP_DEFINES_SVH
`define TRIHEX_CHUNK_NEIGHBOUR_ADDRESSES_TOP_DEFINES_SVH

// clocked assertion, switched off while reset is held
`define TCNA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// clocked assertion that also holds through reset
`define TCNA_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/tcna_pkg.sv -----
// types, constants and the neighbour offset table
`default_nettype none

package tcna_pkg;

  // cell size register
  localparam int SIZE_BITS = 7;
  localparam logic [SIZE_BITS-1:0] SIZE_RESET = 7'd8;

  // neighbour numbering
  localparam int IDX_BITS = 4;
  localparam logic [IDX_BITS-1:0] FIRST_IDX = 4'd0;
  localparam logic [IDX_BITS-1:0] LAST_IDX  = 4'd11;

  // chunk step accumulated over two passes stays within -4..4
  localparam int DK_BITS = 4;

  typedef logic signed [DK_BITS-1:0] dk_t;

  typedef struct packed {
    dk_t a;
    dk_t b;
    dk_t c;
  } dk3_t;

  typedef logic signed [1:0] ofs_t;

  typedef struct packed {
    ofs_t a;
    ofs_t b;
    ofs_t c;
  } ofs3_t;

  // offsets of an upward cell; a downward cell uses the negated entry
  function automatic ofs3_t up_offset(input logic [IDX_BITS-1:0] k);
    ofs3_t o;
    unique case (k)
      4'd0:    o = '{a:  2'sd0, b:  2'sd1, c:  2'sd0};
      4'd1:    o = '{a:  2'sd0, b:  2'sd1, c: -2'sd1};
      4'd2:    o = '{a:  2'sd1, b:  2'sd1, c: -2'sd1};
      4'd3:    o = '{a:  2'sd1, b:  2'sd0, c: -2'sd1};
      4'd4:    o = '{a:  2'sd1, b:  2'sd0, c:  2'sd0};
      4'd5:    o = '{a:  2'sd1, b: -2'sd1, c:  2'sd0};
      4'd6:    o = '{a:  2'sd1, b: -2'sd1, c:  2'sd1};
      4'd7:    o = '{a:  2'sd0, b: -2'sd1, c:  2'sd1};
      4'd8:    o = '{a:  2'sd0, b:  2'sd0, c:  2'sd1};
      4'd9:    o = '{a: -2'sd1, b:  2'sd0, c:  2'sd1};
      4'd10:   o = '{a: -2'sd1, b:  2'sd1, c:  2'sd1};
      4'd11:   o = '{a: -2'sd1, b:  2'sd1, c:  2'sd0};
      default: o = '{a:  2'sd0, b:  2'sd0, c:  2'sd0};
    endcase
    return o;
  endfunction

endpackage

`default_nettype wire

// ----- src/tcna_if.sv -----
// valid/ready channel interfaces for cell addresses and neighbour results
`default_nettype none

interface tcna_in_if #(
  parameter int CHUNK_BITS = 32,
  parameter int CELL_BITS  = 8
) ();
  logic                  valid;
  logic                  ready;
  logic [CHUNK_BITS-1:0] chunk_a;
  logic [CHUNK_BITS-1:0] chunk_b;
  logic [CHUNK_BITS-1:0] chunk_c;
  logic [CELL_BITS-1:0]  cell_a;
  logic [CELL_BITS-1:0]  cell_b;
  logic [CELL_BITS-1:0]  cell_c;

  modport source (
    output valid, chunk_a, chunk_b, chunk_c, cell_a, cell_b, cell_c,
    input  ready
  );
  modport sink (
    input  valid, chunk_a, chunk_b, chunk_c, cell_a, cell_b, cell_c,
    output ready
  );
endinterface

interface tcna_out_if #(
  parameter int CHUNK_BITS = 32,
  parameter int CELL_BITS  = 8
) ();
  logic                           valid;
  logic                           ready;
  logic [tcna_pkg::IDX_BITS-1:0]  neighbour_index;
  logic [CHUNK_BITS-1:0]          out_chunk_a;
  logic [CHUNK_BITS-1:0]          out_chunk_b;
  logic [CHUNK_BITS-1:0]          out_chunk_c;
  logic [CELL_BITS-1:0]           out_cell_a;
  logic [CELL_BITS-1:0]           out_cell_b;
  logic [CELL_BITS-1:0]           out_cell_c;
  logic                           chunk_overflow;
  logic                           last_neighbour;

  modport source (
    output valid, neighbour_index, out_chunk_a, out_chunk_b, out_chunk_c,
           out_cell_a, out_cell_b, out_cell_c, chunk_overflow, last_neighbour,
    input  ready
  );
  modport sink (
    input  valid, neighbour_index, out_chunk_a, out_chunk_b, out_chunk_c,
           out_cell_a, out_cell_b, out_cell_c, chunk_overflow, last_neighbour,
    output ready
  );
endinterface

`default_nettype wire

// ----- src/tcna_norm_pass.sv -----
// one pass of the six chunk normalisation rules, applied in order
`default_nettype none

module tcna_norm_pass #(
  parameter int WW = 14
) (
  input  logic [tcna_pkg::SIZE_BITS-1:0] size_i,
  input  logic [2:0][WW-1:0]             cell_i,
  input  tcna_pkg::dk3_t                 dk_i,
  output logic [2:0][WW-1:0]             cell_o,
  output tcna_pkg::dk3_t                 dk_o
);

  // rules chain: each one sees the cell as left by the one before
  always_comb begin
    logic signed [WW-1:0] sz;
    logic signed [WW-1:0] sz2;
    logic signed [WW-1:0] ca;
    logic signed [WW-1:0] cb;
    logic signed [WW-1:0] cc;
    tcna_pkg::dk_t        da;
    tcna_pkg::dk_t        db;
    tcna_pkg::dk_t        dc;

    sz  = $signed(WW'(size_i));
    sz2 = sz <<< 1;
    ca  = $signed(cell_i[0]);
    cb  = $signed(cell_i[1]);
    cc  = $signed(cell_i[2]);
    da  = dk_i.a;
    db  = dk_i.b;
    dc  = dk_i.c;

    // a above size
    if (ca > sz) begin
      ca = ca - sz2; cb = cb + sz; cc = cc + sz;
      da = da + 4'sd1; dc = dc - 4'sd1;
    end
    // b above size minus one
    if (cb >= sz) begin
      ca = ca + sz; cb = cb - sz2; cc = cc + sz;
      db = db - 4'sd1; dc = dc + 4'sd1;
    end
    // c above size
    if (cc > sz) begin
      ca = ca + sz; cb = cb + sz; cc = cc - sz2;
      da = da - 4'sd1; db = db + 4'sd1;
    end
    // a below one minus size
    if (ca <= -sz) begin
      ca = ca + sz2; cb = cb - sz; cc = cc - sz;
      da = da - 4'sd1; dc = dc + 4'sd1;
    end
    // b below minus size
    if (cb < -sz) begin
      ca = ca - sz; cb = cb + sz2; cc = cc - sz;
      db = db + 4'sd1; dc = dc - 4'sd1;
    end
    // c below one minus size
    if (cc <= -sz) begin
      ca = ca - sz; cb = cb - sz; cc = cc + sz2;
      da = da + 4'sd1; db = db - 4'sd1;
    end

    cell_o[0] = ca;
    cell_o[1] = cb;
    cell_o[2] = cc;
    dk_o.a    = da;
    dk_o.b    = db;
    dk_o.c    = dc;
  end

endmodule

`default_nettype wire

// ----- src/trihex_chunk_neighbour_addresses_top.sv -----
// top level: neighbour address generator for chunked triangle cells
`default_nettype none

// Each accepted cell address produces twelve neighbour results in fixed
// order on the out channel, index 0 to 11, with last_neighbour marking the
// twelfth. The result channel moves one transaction per cycle while the
// receiver holds ready, and the next address is taken while the tail of the
// previous one is still in flight. The first result passes through the
// address register, which loads at the accepting edge, then the stage one
// register after the first normalisation pass, then the output register.
// The user writes cell_size through cfg_we/cfg_wdata only while no address
// is in flight; the block itself does not enforce this. It resets to 8.
module trihex_chunk_neighbour_addresses_top #(
  parameter int CHUNK_BITS = 32,
  parameter int CELL_BITS  = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tcna_pkg::SIZE_BITS-1:0] cfg_wdata,
  tcna_in_if.sink                        in_ch,
  tcna_out_if.source                     out_ch
);

  // working width: input cell range plus sixteen steps of twice the size
  localparam int WW = ((CELL_BITS > 12) ? CELL_BITS : 12) + 2;
  localparam int SUM_BITS = CELL_BITS + 2;

  // cell size register
  logic [tcna_pkg::SIZE_BITS-1:0] size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= tcna_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      size_r <= cfg_wdata;
    end
  end

  // pipeline advance: output free or being taken
  logic adv;
  logic out_v_r;

  assign adv = !out_v_r || out_ch.ready;

  // address register and neighbour counter
  logic                          item_v_r;
  logic                          item_v_nxt;
  logic [tcna_pkg::IDX_BITS-1:0] k_r;
  logic [tcna_pkg::IDX_BITS-1:0] k_nxt;
  logic [CHUNK_BITS-1:0]         ch_a_r;
  logic [CHUNK_BITS-1:0]         ch_b_r;
  logic [CHUNK_BITS-1:0]         ch_c_r;
  logic [CELL_BITS-1:0]          cl_a_r;
  logic [CELL_BITS-1:0]          cl_b_r;
  logic [CELL_BITS-1:0]          cl_c_r;
  logic                          in_take;

  assign in_ch.ready = !item_v_r || (k_r == tcna_pkg::LAST_IDX && adv);
  assign in_take     = in_ch.valid && in_ch.ready;

  // counter walks the twelve neighbours, reloads on a new address
  always_comb begin
    item_v_nxt = item_v_r;
    k_nxt      = k_r;
    if (in_take) begin
      item_v_nxt = 1'b1;
      k_nxt      = tcna_pkg::FIRST_IDX;
    end else if (item_v_r && adv) begin
      if (k_r == tcna_pkg::LAST_IDX) begin
        item_v_nxt = 1'b0;
      end else begin
        k_nxt = k_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
      k_r      <= tcna_pkg::FIRST_IDX;
    end else begin
      item_v_r <= item_v_nxt;
      k_r      <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      ch_a_r <= in_ch.chunk_a;
      ch_b_r <= in_ch.chunk_b;
      ch_c_r <= in_ch.chunk_c;
      cl_a_r <= in_ch.cell_a;
      cl_b_r <= in_ch.cell_b;
      cl_c_r <= in_ch.cell_c;
    end
  end

  // orientation and candidate cell for neighbour k
  logic signed [SUM_BITS-1:0] cell_sum;
  logic                       is_up;
  tcna_pkg::ofs3_t            ofs;
  logic [2:0][WW-1:0]         cand;

  always_comb begin
    cell_sum = SUM_BITS'($signed(cl_a_r)) + SUM_BITS'($signed(cl_b_r))
             + SUM_BITS'($signed(cl_c_r));
    is_up    = (cell_sum == '0);
    ofs      = tcna_pkg::up_offset(k_r);
    if (is_up) begin
      cand[0] = WW'($signed(cl_a_r)) + WW'(ofs.a);
      cand[1] = WW'($signed(cl_b_r)) + WW'(ofs.b);
      cand[2] = WW'($signed(cl_c_r)) + WW'(ofs.c);
    end else begin
      cand[0] = WW'($signed(cl_a_r)) - WW'(ofs.a);
      cand[1] = WW'($signed(cl_b_r)) - WW'(ofs.b);
      cand[2] = WW'($signed(cl_c_r)) - WW'(ofs.c);
    end
  end

  // first normalisation pass
  logic [2:0][WW-1:0] p1_cell;
  tcna_pkg::dk3_t     p1_dk;

  tcna_norm_pass #(.WW(WW)) u_pass1 (
    .size_i (size_r),
    .cell_i (cand),
    .dk_i   ('0),
    .cell_o (p1_cell),
    .dk_o   (p1_dk)
  );

  // stage one register
  logic                          s1_v_r;
  logic [tcna_pkg::IDX_BITS-1:0] s1_k_r;
  logic [CHUNK_BITS-1:0]         s1_ch_a_r;
  logic [CHUNK_BITS-1:0]         s1_ch_b_r;
  logic [CHUNK_BITS-1:0]         s1_ch_c_r;
  logic [2:0][WW-1:0]            s1_cell_r;
  tcna_pkg::dk3_t                s1_dk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= item_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_k_r    <= k_r;
      s1_ch_a_r <= ch_a_r;
      s1_ch_b_r <= ch_b_r;
      s1_ch_c_r <= ch_c_r;
      s1_cell_r <= p1_cell;
      s1_dk_r   <= p1_dk;
    end
  end

  // second normalisation pass
  logic [2:0][WW-1:0] p2_cell;
  tcna_pkg::dk3_t     p2_dk;

  tcna_norm_pass #(.WW(WW)) u_pass2 (
    .size_i (size_r),
    .cell_i (s1_cell_r),
    .dk_i   (s1_dk_r),
    .cell_o (p2_cell),
    .dk_o   (p2_dk)
  );

  // chunk update with signed overflow detect
  logic [CHUNK_BITS:0] sum_a;
  logic [CHUNK_BITS:0] sum_b;
  logic [CHUNK_BITS:0] sum_c;
  logic                ovf;

  always_comb begin
    sum_a = {s1_ch_a_r[CHUNK_BITS-1], s1_ch_a_r} + (CHUNK_BITS+1)'(p2_dk.a);
    sum_b = {s1_ch_b_r[CHUNK_BITS-1], s1_ch_b_r} + (CHUNK_BITS+1)'(p2_dk.b);
    sum_c = {s1_ch_c_r[CHUNK_BITS-1], s1_ch_c_r} + (CHUNK_BITS+1)'(p2_dk.c);
    ovf   = (sum_a[CHUNK_BITS] ^ sum_a[CHUNK_BITS-1])
          | (sum_b[CHUNK_BITS] ^ sum_b[CHUNK_BITS-1])
          | (sum_c[CHUNK_BITS] ^ sum_c[CHUNK_BITS-1]);
  end

  // output register
  logic [tcna_pkg::IDX_BITS-1:0] out_k_r;
  logic [CHUNK_BITS-1:0]         out_ch_a_r;
  logic [CHUNK_BITS-1:0]         out_ch_b_r;
  logic [CHUNK_BITS-1:0]         out_ch_c_r;
  logic [CELL_BITS-1:0]          out_cl_a_r;
  logic [CELL_BITS-1:0]          out_cl_b_r;
  logic [CELL_BITS-1:0]          out_cl_c_r;
  logic                          out_ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_k_r    <= s1_k_r;
      out_ch_a_r <= sum_a[CHUNK_BITS-1:0];
      out_ch_b_r <= sum_b[CHUNK_BITS-1:0];
      out_ch_c_r <= sum_c[CHUNK_BITS-1:0];
      out_cl_a_r <= p2_cell[0][CELL_BITS-1:0];
      out_cl_b_r <= p2_cell[1][CELL_BITS-1:0];
      out_cl_c_r <= p2_cell[2][CELL_BITS-1:0];
      out_ovf_r  <= ovf;
    end
  end

  // result channel
  assign out_ch.valid           = out_v_r;
  assign out_ch.neighbour_index = out_k_r;
  assign out_ch.out_chunk_a     = out_ch_a_r;
  assign out_ch.out_chunk_b     = out_ch_b_r;
  assign out_ch.out_chunk_c     = out_ch_c_r;
  assign out_ch.out_cell_a      = out_cl_a_r;
  assign out_ch.out_cell_b      = out_cl_b_r;
  assign out_ch.out_cell_c      = out_cl_c_r;
  assign out_ch.chunk_overflow  = out_ovf_r;
  assign out_ch.last_neighbour  = (out_k_r == tcna_pkg::LAST_IDX);

endmodule

`default_nettype wire

// ----- src/tcna_checker.sv -----
// port-level checks on the neighbour result sequence, bound to the top level
`default_nettype none

`include "trihex_chunk_neighbour_addresses_top_defines.svh"

module tcna_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [tcna_pkg::IDX_BITS-1:0] neighbour_index,
  input wire logic                          last_neighbour
);

  // last flag marks exactly the twelfth neighbour
  `TCNA_ASSERT(a_last_flag, out_valid |-> (last_neighbour == (neighbour_index == tcna_pkg::LAST_IDX)), "last_neighbour does not match index")

  // within a run the next neighbour follows directly
  `TCNA_ASSERT(a_index_step, out_valid && out_ready && neighbour_index != tcna_pkg::LAST_IDX |=> out_valid && neighbour_index == $past(neighbour_index) + 4'd1, "neighbour index did not advance by one")

  // a new run starts at neighbour zero
  `TCNA_ASSERT(a_run_start, out_valid && out_ready && neighbour_index == tcna_pkg::LAST_IDX |=> !out_valid || neighbour_index == tcna_pkg::FIRST_IDX, "run did not restart at index zero")

  // reset empties the result register
  `TCNA_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind trihex_chunk_neighbour_addresses_top tcna_checker u_tcna_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .neighbour_index (out_ch.neighbour_index),
  .last_neighbour  (out_ch.last_neighbour)
);

`default_nettype wire

// ----- tb/sv/tb_trihex_chunk_neighbour_addresses_top.sv -----
// testbench: neighbour address generator checked against a behavioral predictor
`timescale 1ns / 1ps

module tb_trihex_chunk_neighbour_addresses_top;

  localparam int CHUNK_BITS = 32;
  localparam int CELL_BITS  = 8;
  localparam int SIZE_BITS  = tcna_pkg::SIZE_BITS;
  localparam int IDX_BITS   = tcna_pkg::IDX_BITS;
  localparam int NBR_COUNT  = 12;
  localparam int PASSES     = 2;
  localparam int PHASES     = 7;
  localparam int PHASE_ITEMS = 16;
  localparam longint CHUNK_MAX = (longint'(1) <<< (CHUNK_BITS - 1)) - 1;
  localparam longint CHUNK_MIN = -CHUNK_MAX - 1;

  // offsets of an upward cell, one row per neighbour in output order
  localparam int UP_OFFSETS [NBR_COUNT][3] = '{
    '{ 0,  1,  0}, '{ 0,  1, -1}, '{ 1,  1, -1}, '{ 1,  0, -1},
    '{ 1,  0,  0}, '{ 1, -1,  0}, '{ 1, -1,  1}, '{ 0, -1,  1},
    '{ 0,  0,  1}, '{-1,  0,  1}, '{-1,  1,  1}, '{-1,  1,  0}
  };

  typedef struct {
    logic signed [CHUNK_BITS-1:0] chunk_a, chunk_b, chunk_c;
    logic signed [CELL_BITS-1:0]  cell_a, cell_b, cell_c;
  } cell_addr_t;

  typedef struct {
    logic [IDX_BITS-1:0]   nbr_index;
    logic [CHUNK_BITS-1:0] chunk_a, chunk_b, chunk_c;
    logic [CELL_BITS-1:0]  cell_a, cell_b, cell_c;
    logic                  overflow;
    logic                  last_nbr;
  } neighbour_t;

  typedef struct {
    cell_addr_t addr;
    bit         typed;
    neighbour_t first;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [SIZE_BITS-1:0] cfg_wdata = '0;
  logic result_ready = 1'b0;

  logic [SIZE_BITS-1:0] cell_size_q;
  neighbour_t pending_neighbours [$];
  directed_row_t directed_rows [$];
  bit steady = 1'b0;
  int result_stall;
  int fail_count = 0;

  tcna_in_if  #(.CHUNK_BITS(CHUNK_BITS), .CELL_BITS(CELL_BITS)) in_ch ();
  tcna_out_if #(.CHUNK_BITS(CHUNK_BITS), .CELL_BITS(CELL_BITS)) out_ch ();

  assign out_ch.ready = result_ready;

  trihex_chunk_neighbour_addresses_top #(
    .CHUNK_BITS(CHUNK_BITS),
    .CELL_BITS (CELL_BITS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // expected twelve neighbours of one address under the current cell size
  function automatic void predict_neighbours(input cell_addr_t addr);
    longint chunk [3];
    longint moved [3];
    int base [3];
    int cl [3];
    int dk [3];
    int s;
    int dir;
    int k;
    int i;
    neighbour_t n;
    s = int'(cell_size_q);
    chunk[0] = addr.chunk_a;
    chunk[1] = addr.chunk_b;
    chunk[2] = addr.chunk_c;
    base[0] = addr.cell_a;
    base[1] = addr.cell_b;
    base[2] = addr.cell_c;
    // upward cell only when the coordinates sum to zero
    dir = (base[0] + base[1] + base[2] == 0) ? 1 : -1;
    for (k = 0; k < NBR_COUNT; k++) begin
      for (i = 0; i < 3; i++) begin
        cl[i] = base[i] + dir * UP_OFFSETS[k][i];
        dk[i] = 0;
      end
      // fixed number of normalisation passes, rules in order
      repeat (PASSES) begin
        if (cl[0] > s) begin
          cl[0] -= 2 * s; cl[1] += s; cl[2] += s; dk[0]++; dk[2]--;
        end
        if (cl[1] > s - 1) begin
          cl[0] += s; cl[1] -= 2 * s; cl[2] += s; dk[1]--; dk[2]++;
        end
        if (cl[2] > s) begin
          cl[0] += s; cl[1] += s; cl[2] -= 2 * s; dk[0]--; dk[1]++;
        end
        if (cl[0] < 1 - s) begin
          cl[0] += 2 * s; cl[1] -= s; cl[2] -= s; dk[0]--; dk[2]++;
        end
        if (cl[1] < -s) begin
          cl[0] -= s; cl[1] += 2 * s; cl[2] -= s; dk[1]++; dk[2]--;
        end
        if (cl[2] < 1 - s) begin
          cl[0] -= s; cl[1] -= s; cl[2] += 2 * s; dk[0]++; dk[1]--;
        end
      end
      // chunk step with wrap and overflow flag
      n.overflow = 1'b0;
      for (i = 0; i < 3; i++) begin
        moved[i] = chunk[i] + dk[i];
        if (moved[i] > CHUNK_MAX || moved[i] < CHUNK_MIN) n.overflow = 1'b1;
      end
      n.nbr_index = IDX_BITS'(k);
      n.chunk_a   = CHUNK_BITS'(moved[0]);
      n.chunk_b   = CHUNK_BITS'(moved[1]);
      n.chunk_c   = CHUNK_BITS'(moved[2]);
      n.cell_a    = CELL_BITS'(cl[0]);
      n.cell_b    = CELL_BITS'(cl[1]);
      n.cell_c    = CELL_BITS'(cl[2]);
      n.last_nbr  = (IDX_BITS'(k) == tcna_pkg::LAST_IDX);
      pending_neighbours.insert(pending_neighbours.size(), n);
    end
  endfunction

  // one directed row, optionally with its first neighbour spelled out
  function automatic void add_row(
    input logic signed [CHUNK_BITS-1:0] ca, cb, cc,
    input logic signed [CELL_BITS-1:0]  la, lb, lc,
    input bit typed = 1'b0,
    input logic [CHUNK_BITS-1:0] ea = '0, eb = '0, ec = '0,
    input logic [CELL_BITS-1:0]  xa = '0, xb = '0, xc = '0,
    input logic eovf = 1'b0
  );
    directed_row_t r;
    r.addr = '{chunk_a: ca, chunk_b: cb, chunk_c: cc, cell_a: la, cell_b: lb, cell_c: lc};
    r.typed = typed;
    r.first = '{nbr_index: tcna_pkg::FIRST_IDX, chunk_a: ea, chunk_b: eb, chunk_c: ec,
                cell_a: xa, cell_b: xb, cell_c: xc, overflow: eovf, last_nbr: 1'b0};
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  // chunk coordinate, often next to either end of the range
  function automatic logic [CHUNK_BITS-1:0] random_chunk();
    case ($urandom_range(0, 3))
      0:       return CHUNK_BITS'(CHUNK_MAX - longint'($urandom_range(0, 2)));
      1:       return CHUNK_BITS'(CHUNK_MIN + longint'($urandom_range(0, 2)));
      default: return CHUNK_BITS'($urandom());
    endcase
  endfunction

  // mostly proper cells inside the chunk, some raw bit patterns
  function automatic cell_addr_t random_address(input int s);
    cell_addr_t a;
    int ca;
    int cb;
    a.chunk_a = random_chunk();
    a.chunk_b = random_chunk();
    a.chunk_c = random_chunk();
    if ($urandom_range(0, 9) < 8) begin
      ca = int'($urandom_range(0, 2 * s)) - s;
      cb = int'($urandom_range(0, 2 * s)) - s;
      a.cell_a = CELL_BITS'(ca);
      a.cell_b = CELL_BITS'(cb);
      a.cell_c = CELL_BITS'(-ca - cb + int'($urandom_range(0, 1)));
    end else begin
      a.cell_a = CELL_BITS'($urandom());
      a.cell_b = CELL_BITS'($urandom());
      a.cell_c = CELL_BITS'($urandom());
    end
    return a;
  endfunction

  function automatic void compare_field(
    input string name, input logic [CHUNK_BITS-1:0] want, input logic [CHUNK_BITS-1:0] got
  );
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // present one address after a random gap (none in steady phases) and wait for its transaction
  task automatic send_address(input cell_addr_t addr);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.chunk_a <= addr.chunk_a;
    in_ch.chunk_b <= addr.chunk_b;
    in_ch.chunk_c <= addr.chunk_c;
    in_ch.cell_a  <= addr.cell_a;
    in_ch.cell_b  <= addr.cell_b;
    in_ch.cell_c  <= addr.cell_c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_neighbours(addr);
  endtask

  // stop sending and wait until every neighbour has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_neighbours.size() != 0) @(posedge clk);
  endtask

  // result side drops ready for a random stall after each transaction, except in steady phases
  always @(posedge clk) begin
    if (!rst_n) begin
      result_ready <= 1'b0;
      result_stall = 0;
    end else if (result_ready) begin
      if (out_ch.valid) begin
        result_stall = steady ? 0 : $urandom_range(0, 10);
        if (result_stall != 0) result_ready <= 1'b0;
      end
    end else begin
      result_stall--;
      if (result_stall <= 0) result_ready <= 1'b1;
    end
  end

  // compare each result transaction with the oldest expected neighbour
  always @(posedge clk) begin
    neighbour_t n;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_neighbours.size() == 0) begin
        $error("unexpected neighbour result, index %0d", out_ch.neighbour_index);
        fail_count++;
      end else begin
        n = pending_neighbours.pop_front();
        compare_field("neighbour_index", n.nbr_index, out_ch.neighbour_index);
        compare_field("out_chunk_a", n.chunk_a, out_ch.out_chunk_a);
        compare_field("out_chunk_b", n.chunk_b, out_ch.out_chunk_b);
        compare_field("out_chunk_c", n.chunk_c, out_ch.out_chunk_c);
        compare_field("out_cell_a", n.cell_a, out_ch.out_cell_a);
        compare_field("out_cell_b", n.cell_b, out_ch.out_cell_b);
        compare_field("out_cell_c", n.cell_c, out_ch.out_cell_c);
        compare_field("chunk_overflow", n.overflow, out_ch.chunk_overflow);
        compare_field("last_neighbour", n.last_nbr, out_ch.last_neighbour);
      end
    end
  end

  // main sequence
  initial begin
    logic [SIZE_BITS-1:0] next_size;
    int p;
    in_ch.valid   = 1'b0;
    in_ch.chunk_a = '0;
    in_ch.chunk_b = '0;
    in_ch.chunk_c = '0;
    in_ch.cell_a  = '0;
    in_ch.cell_b  = '0;
    in_ch.cell_c  = '0;
    cell_size_q   = tcna_pkg::SIZE_RESET;

    // directed rows, run at the reset cell size of 8
    add_row(0, 0, 0, 0, 0, 0,
            1'b1, 0, 0, 0, 8'h00, 8'h01, 8'h00, 1'b0);
    // both chunk a and b step past the range ends
    add_row(32'h7FFF_FFFF, 32'h8000_0000, 0, 8, 0, -8,
            1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 0, 8'h00, 8'hF9, 8'h08, 1'b1);
    // downward cell uses the negated offsets
    add_row(5, -3, -2, 1, 0, 0,
            1'b1, 32'd5, 32'hFFFF_FFFD, 32'hFFFF_FFFE, 8'h01, 8'hFF, 8'h00, 1'b0);
    add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8, -7, 0);
    add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, -7, 0, 7);
    add_row(-1, -1, -1, 0, 8, -8);
    add_row(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 0, -8, 8);
    add_row(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, -8, 8, 0);
    // cells far outside the chunk, two passes only
    add_row(0, 0, 0, 127, 127, 127);
    add_row(0, 0, 0, -128, -128, -128);
    add_row(1, -1, 0, -128, 127, 1);
    add_row(0, 0, 0, 64, -64, 0);
    add_row(0, 0, 0, -64, 64, 1);
    // coordinate sums neither 0 nor 1, then more cells that sum to zero
    add_row(0, 0, 0, 3, 0, 0);
    add_row(0, 0, 0, 0, 0, -1);
    add_row(0, 0, 0, 8'h55, 8'hAA, 0);
    add_row(32'h7FFF_FFFE, 32'h8000_0001, 0, 8, -8, 0);
    add_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678, -8, 0, 8);
    add_row(0, 0, 0, 8, 8, -16);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_address(directed_rows[i].addr);
      if (directed_rows[i].typed)
        pending_neighbours[pending_neighbours.size() - NBR_COUNT] = directed_rows[i].first;
    end

    // random phases, cell size changed only once the block is drained
    for (p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        case (p)
          1:       next_size = 7'd1;
          2:       next_size = 7'd64;
          3:       next_size = 7'd0;
          4:       next_size = 7'd127;
          default: next_size = SIZE_BITS'($urandom_range(2, 63));
        endcase
        drain_results();
        cfg_we      <= 1'b1;
        cfg_wdata   <= next_size;
        cell_size_q = next_size;
        @(posedge clk);
        cfg_we <= 1'b0;
      end
      steady = (p % 3 == 2);
      repeat (PHASE_ITEMS) send_address(random_address(int'(cell_size_q)));
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
